[hw/rtl/ipmc_pkg.sv]
// Shared types and constants for the inactivity power mode controller.
package ipmc_pkg;

    localparam int unsigned TIMER_W = 25;
    localparam int unsigned TMO_W   = 24;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned DELAY_W = 25;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 24;

    typedef enum logic [1:0] {
        MODE_ACTIVE = 2'd0,
        MODE_IDLE   = 2'd1,
        MODE_STOP   = 2'd2
    } t_mode;

    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACTIVITY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WAKE     = 2'd2;

    localparam logic [IDX_W-1:0] REG_ACTIVE_TIMEOUT = 2'd0;
    localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_STOP_WAKE      = 2'd2;
    localparam logic [IDX_W-1:0] REG_FAULT_THRESH   = 2'd3;

    localparam logic [TMO_W-1:0] RST_ACTIVE_TIMEOUT = 24'd30000;
    localparam logic [TMO_W-1:0] RST_IDLE_TIMEOUT   = 24'd5000;
    localparam logic [TMO_W-1:0] RST_STOP_WAKE      = 24'd60000;
    localparam logic [CNT_W-1:0] RST_FAULT_THRESH   = 8'd3;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    localparam logic signed [DELAY_W:0] DELAY_HI_WIDE = 26'sd16777215;
    localparam logic signed [DELAY_W:0] DELAY_LO_WIDE = -26'sd16777216;
    localparam logic [DELAY_W-1:0]      DELAY_HI      = 25'h0FF_FFFF;
    localparam logic [DELAY_W-1:0]      DELAY_LO      = 25'h100_0000;

endpackage

[hw/rtl/inactivity_power_mode_controller_unit.sv]
// Top level of the inactivity power mode controller (Active / Idle / Stop).
//
// Input channel: i_valid / o_stall carry one command per transaction (1 ms tick,
// activity report or RTC wake) plus the Stop preparation and resume status bits.
// Output channel: o_valid / i_stall carry one result per input transaction: the
// mode after the command, entry / abort / wake pulses, wake delay, failure count
// and fault pulse.
// Flow: a taken transaction lands in the input register, is evaluated against
// the mode and timer state and moves to the output register when that one is
// empty or i_stall is low. Throughput is one transaction per cycle while i_stall
// is low; the state update is one pass of compares and increments in between.
// Stall: when i_stall holds a valid result, the input register waits and o_stall
// rises only while it is full, so one more transaction is still taken.
// Reset (synchronous, i_rst_n low): Active mode, timers and failure count cleared,
// both registers empty, configuration back to 30000 / 5000 / 60000 ms and a
// threshold of 3. Configuration writes through i_cfg_we land at once; make them
// only while no transaction is in flight.
module inactivity_power_mode_controller_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ipmc_pkg::CMD_W-1:0]   i_cmd,
    input  logic                         i_stop_prep_ok,
    input  logic                         i_resume_good,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_mode,
    output logic                         o_sleep_entered,
    output logic                         o_sleep_aborted,
    output logic                         o_woke_up,
    output logic signed [ipmc_pkg::DELAY_W-1:0] o_wake_delay_ms,
    output logic [ipmc_pkg::CNT_W-1:0]   o_failure_count,
    output logic                         o_fault,
    input  logic                         i_cfg_we,
    input  logic [ipmc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [ipmc_pkg::CFG_W-1:0]   i_cfg_data
);

    // configuration
    logic [ipmc_pkg::TMO_W-1:0] r_active_tmo;
    logic [ipmc_pkg::TMO_W-1:0] r_idle_tmo;
    logic [ipmc_pkg::TMO_W-1:0] r_stop_wake;
    logic [ipmc_pkg::CNT_W-1:0] r_fault_thr;

    // state
    ipmc_pkg::t_mode              r_mode, n_mode;
    logic [ipmc_pkg::TIMER_W-1:0] r_inact, n_inact;
    logic [ipmc_pkg::TIMER_W-1:0] r_stop_time, n_stop_time;
    logic [ipmc_pkg::CNT_W-1:0]   r_fail, n_fail;

    // input register
    logic                       r_in_valid;
    logic [ipmc_pkg::CMD_W-1:0] r_cmd;
    logic                       r_prep_ok;
    logic                       r_res_ok;

    // output register
    logic                                r_out_valid;
    ipmc_pkg::t_mode                     r_out_mode;
    logic                                r_out_entered, n_entered;
    logic                                r_out_aborted, n_aborted;
    logic                                r_out_woke, n_woke;
    logic signed [ipmc_pkg::DELAY_W-1:0] r_out_delay, n_delay;
    logic [ipmc_pkg::CNT_W-1:0]          r_out_fail;
    logic                                r_out_fault, n_fault;

    logic                                adv;
    logic                                in_take;
    ipmc_pkg::t_mode                     cur_mode;
    logic [ipmc_pkg::TIMER_W-1:0]        inact_inc;
    logic [ipmc_pkg::TIMER_W-1:0]        stop_inc;
    logic [ipmc_pkg::TIMER_W-1:0]        idle_limit;
    logic                                hit_active;
    logic                                hit_idle;
    logic [ipmc_pkg::CNT_W-1:0]          fail_inc;
    logic                                fail_fault;
    logic signed [ipmc_pkg::DELAY_W:0]   delay_wide;

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign in_take = i_valid && !o_stall;

    // code 3 cannot arise; fold it to Active anyway
    always_comb begin
        unique case (r_mode)
            ipmc_pkg::MODE_IDLE: cur_mode = ipmc_pkg::MODE_IDLE;
            ipmc_pkg::MODE_STOP: cur_mode = ipmc_pkg::MODE_STOP;
            default:             cur_mode = ipmc_pkg::MODE_ACTIVE;
        endcase
    end

    assign inact_inc  = (r_inact == ipmc_pkg::TIMER_MAX) ? r_inact : r_inact + 1'b1;
    assign stop_inc   = (r_stop_time == ipmc_pkg::TIMER_MAX) ? r_stop_time
                                                             : r_stop_time + 1'b1;
    assign idle_limit = {1'b0, r_active_tmo} + {1'b0, r_idle_tmo};
    assign hit_active = inact_inc >= {1'b0, r_active_tmo};
    assign hit_idle   = inact_inc >= idle_limit;

    assign fail_inc   = (r_fail == ipmc_pkg::CNT_MAX) ? r_fail : r_fail + 1'b1;
    assign fail_fault = (r_fail != ipmc_pkg::CNT_MAX) && (fail_inc == r_fault_thr);

    assign delay_wide = $signed({1'b0, r_stop_time}) - $signed({2'b00, r_stop_wake});

    // next mode
    always_comb begin
        n_mode = cur_mode;
        unique case (r_cmd)
            ipmc_pkg::CMD_TICK: begin
                if (cur_mode == ipmc_pkg::MODE_ACTIVE && hit_active) begin
                    n_mode = ipmc_pkg::MODE_IDLE;
                end else if (cur_mode == ipmc_pkg::MODE_IDLE && hit_idle && r_prep_ok) begin
                    n_mode = ipmc_pkg::MODE_STOP;
                end
            end
            ipmc_pkg::CMD_ACTIVITY, ipmc_pkg::CMD_WAKE: begin
                n_mode = ipmc_pkg::MODE_ACTIVE;
            end
            default: begin
                n_mode = cur_mode;
            end
        endcase
    end

    // timers, failure count and result pulses
    always_comb begin
        n_inact     = r_inact;
        n_stop_time = r_stop_time;
        n_fail      = r_fail;
        n_entered   = 1'b0;
        n_aborted   = 1'b0;
        n_woke      = 1'b0;
        n_delay     = '0;
        n_fault     = 1'b0;
        unique case (r_cmd)
            ipmc_pkg::CMD_TICK: begin
                n_inact = inact_inc;
                if (cur_mode == ipmc_pkg::MODE_STOP) begin
                    n_stop_time = stop_inc;
                end else if (cur_mode == ipmc_pkg::MODE_IDLE && hit_idle) begin
                    if (r_prep_ok) begin
                        n_stop_time = '0;
                        n_entered   = 1'b1;
                    end else begin
                        n_aborted = 1'b1;
                        n_fail    = fail_inc;
                        n_fault   = fail_fault;
                    end
                end
            end
            ipmc_pkg::CMD_ACTIVITY, ipmc_pkg::CMD_WAKE: begin
                n_inact = '0;
                if (cur_mode == ipmc_pkg::MODE_STOP) begin
                    n_woke = 1'b1;
                    if (delay_wide > ipmc_pkg::DELAY_HI_WIDE) begin
                        n_delay = ipmc_pkg::DELAY_HI;
                    end else if (delay_wide < ipmc_pkg::DELAY_LO_WIDE) begin
                        n_delay = ipmc_pkg::DELAY_LO;
                    end else begin
                        n_delay = delay_wide[ipmc_pkg::DELAY_W-1:0];
                    end
                    if (r_res_ok) begin
                        n_fail = '0;
                    end else begin
                        n_fail  = fail_inc;
                        n_fault = fail_fault;
                    end
                end
            end
            default: begin
                n_inact = r_inact;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_tmo <= ipmc_pkg::RST_ACTIVE_TIMEOUT;
            r_idle_tmo   <= ipmc_pkg::RST_IDLE_TIMEOUT;
            r_stop_wake  <= ipmc_pkg::RST_STOP_WAKE;
            r_fault_thr  <= ipmc_pkg::RST_FAULT_THRESH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ipmc_pkg::REG_ACTIVE_TIMEOUT: r_active_tmo <= i_cfg_data;
                ipmc_pkg::REG_IDLE_TIMEOUT:   r_idle_tmo   <= i_cfg_data;
                ipmc_pkg::REG_STOP_WAKE:      r_stop_wake  <= i_cfg_data;
                ipmc_pkg::REG_FAULT_THRESH:   r_fault_thr  <= i_cfg_data[ipmc_pkg::CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ipmc_pkg::MODE_ACTIVE;
            r_inact     <= '0;
            r_stop_time <= '0;
            r_fail      <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_mode      <= n_mode;
                r_inact     <= n_inact;
                r_stop_time <= n_stop_time;
                r_fail      <= n_fail;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd     <= i_cmd;
            r_prep_ok <= i_stop_prep_ok;
            r_res_ok  <= i_resume_good;
        end
        if (adv) begin
            r_out_mode    <= n_mode;
            r_out_entered <= n_entered;
            r_out_aborted <= n_aborted;
            r_out_woke    <= n_woke;
            r_out_delay   <= n_delay;
            r_out_fail    <= n_fail;
            r_out_fault   <= n_fault;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_mode          = r_out_mode;
    assign o_sleep_entered = r_out_entered;
    assign o_sleep_aborted = r_out_aborted;
    assign o_woke_up       = r_out_woke;
    assign o_wake_delay_ms = r_out_delay;
    assign o_failure_count = r_out_fail;
    assign o_fault         = r_out_fault;

endmodule

[hw/rtl/ipmc_checker.sv]
// Port-level checker for the inactivity power mode controller, bound to the top level.
module ipmc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [1:0]                   o_mode,
    input logic                         o_sleep_entered,
    input logic                         o_sleep_aborted,
    input logic                         o_woke_up,
    input logic signed [ipmc_pkg::DELAY_W-1:0] o_wake_delay_ms,
    input logic [ipmc_pkg::CNT_W-1:0]   o_failure_count,
    input logic                         o_fault
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mode) && $stable(o_failure_count)
                               && $stable(o_wake_delay_ms))
        else $error("stalled result changed");

    // a successful Stop entry always reports Stop
    a_entered_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sleep_entered |-> o_mode == ipmc_pkg::MODE_STOP && !o_sleep_aborted)
        else $error("sleep entry without Stop mode");

    // an aborted attempt leaves the block in Idle
    a_aborted_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sleep_aborted |-> o_mode == ipmc_pkg::MODE_IDLE)
        else $error("sleep abort outside Idle");

    // a wake always lands in Active; delay is zero without a wake
    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_woke_up ? o_mode == ipmc_pkg::MODE_ACTIVE : o_wake_delay_ms == '0))
        else $error("wake report inconsistent");

    // fault only with a nonzero failure count
    a_fault_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fault |-> o_failure_count != '0)
        else $error("fault with zero failure count");

endmodule

bind inactivity_power_mode_controller_unit ipmc_checker u_ipmc_checker (.*);
